[design/dfx_pkg.sv]
`timescale 1ns / 1ps
package dfx_pkg;

  localparam int ID_BITS             = 8;
  localparam int ID_ACC_BITS         = ID_BITS + 1;
  localparam int ID_CALC_BITS        = ID_ACC_BITS + 4;
  localparam int MANTISSA_BITS       = 32;
  localparam int MANT_CALC_BITS      = MANTISSA_BITS + 4;
  localparam int MAX_FRACTION_DIGITS = 9;
  localparam int FRACTION_BITS       = 4;
  localparam int CHECKSUM_BITS       = 16;
  localparam int CHECKSUM_CALC_BITS  = CHECKSUM_BITS + 4;
  localparam int SEP_COUNT_BITS      = 3;
  localparam int STATUS_BITS         = 3;
  localparam int CFG_INDEX_BITS      = 1;
  localparam int CFG_DATA_BITS       = 8;
  localparam int IN_DATA_BITS        = 8;
  localparam int OUT_FIELD_BITS      = STATUS_BITS + 2 * ID_BITS + MANTISSA_BITS + FRACTION_BITS;
  localparam int OUT_DATA_BITS       = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [7:0] CHAR_SEPARATOR = 8'h24;
  localparam logic [7:0] CHAR_PLUS      = 8'h2B;
  localparam logic [7:0] CHAR_MINUS     = 8'h2D;
  localparam logic [7:0] CHAR_POINT     = 8'h2E;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F   = 8'h46;

  localparam logic [SEP_COUNT_BITS-1:0] SEPARATORS_NEEDED = SEP_COUNT_BITS'(5);
  localparam logic [SEP_COUNT_BITS-1:0] FIELD_SENSOR      = SEP_COUNT_BITS'(1);
  localparam logic [SEP_COUNT_BITS-1:0] FIELD_VALUE       = SEP_COUNT_BITS'(2);
  localparam logic [SEP_COUNT_BITS-1:0] FIELD_NUMBER      = SEP_COUNT_BITS'(3);
  localparam logic [SEP_COUNT_BITS-1:0] FIELD_CHECKSUM    = SEP_COUNT_BITS'(4);

  localparam logic [CFG_INDEX_BITS-1:0] REG_SENSOR_COUNT = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_VALUE_COUNT  = CFG_INDEX_BITS'(1);

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_ACCEPTED   = 3'd0,
    STATUS_INCOMPLETE = 3'd1,
    STATUS_CHECKSUM   = 3'd2,
    STATUS_DUPLICATE  = 3'd3,
    STATUS_RANGE      = 3'd4
  } status_t;

  typedef struct packed {
    logic                      incomplete;
    logic [7:0]                running_xor;
    logic [CHECKSUM_BITS-1:0]  checksum;
    logic [ID_ACC_BITS-1:0]    sensor_id;
    logic [ID_ACC_BITS-1:0]    value_id;
    logic                      number_ok;
    logic                      negative;
    logic [MANTISSA_BITS-1:0]  magnitude;
    logic [FRACTION_BITS-1:0]  fraction;
  } frame_summary_t;

endpackage

[design/dfx_field_parser.sv]
`timescale 1ns / 1ps
module dfx_field_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [dfx_pkg::IN_DATA_BITS-1:0] s_tdata,  // frame_byte
  input  logic                          s_tlast,
  output logic                          summary_valid,
  input  logic                          summary_ready,
  output dfx_pkg::frame_summary_t       summary
);

  localparam logic [dfx_pkg::ID_CALC_BITS-1:0] ID_LIMIT =
    dfx_pkg::ID_CALC_BITS'(1) << dfx_pkg::ID_BITS;
  localparam logic [dfx_pkg::MANT_CALC_BITS-1:0] MANT_CAP =
    dfx_pkg::MANT_CALC_BITS'(1) << (dfx_pkg::MANTISSA_BITS - 1);
  localparam logic [dfx_pkg::CHECKSUM_CALC_BITS-1:0] CHECKSUM_MAX =
    dfx_pkg::CHECKSUM_CALC_BITS'((1 << dfx_pkg::CHECKSUM_BITS) - 1);
  localparam logic [dfx_pkg::FRACTION_BITS-1:0] FRACTION_LIMIT =
    dfx_pkg::FRACTION_BITS'(dfx_pkg::MAX_FRACTION_DIGITS);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       summary_free;
  logic       consume;

  logic [dfx_pkg::SEP_COUNT_BITS-1:0] sep_count, sep_count_next;
  logic [7:0]                         running_xor, running_xor_next;
  logic [dfx_pkg::ID_ACC_BITS-1:0]    sensor_acc, sensor_acc_next;
  logic [dfx_pkg::ID_ACC_BITS-1:0]    value_acc, value_acc_next;
  logic [dfx_pkg::MANTISSA_BITS-1:0]  mant_acc, mant_acc_next;
  logic                               negative, negative_next;
  logic                               started, started_next;
  logic                               has_digit, has_digit_next;
  logic                               point_seen, point_seen_next;
  logic [dfx_pkg::FRACTION_BITS-1:0]  fraction, fraction_next;
  logic [3:0]                         invalid, invalid_next;
  logic [dfx_pkg::CHECKSUM_BITS-1:0]  checksum, checksum_next;

  logic                                  is_digit;
  logic [3:0]                            digit;
  logic                                  is_hex;
  logic [3:0]                            hex_digit;
  logic [dfx_pkg::ID_CALC_BITS-1:0]      sensor_prod, value_prod;
  logic [dfx_pkg::MANT_CALC_BITS-1:0]    mant_prod;
  logic [dfx_pkg::CHECKSUM_CALC_BITS-1:0] checksum_prod;

  assign summary_free = !summary_valid || summary_ready;
  assign consume      = in_valid && (!in_last || summary_free);
  assign s_tready     = !in_valid || consume;

  assign is_digit = (in_byte >= dfx_pkg::CHAR_ZERO) && (in_byte <= dfx_pkg::CHAR_NINE);
  assign digit    = 4'(in_byte - dfx_pkg::CHAR_ZERO);

  always_comb begin
    is_hex    = 1'b1;
    hex_digit = digit;
    if (is_digit) begin
      hex_digit = digit;
    end else if (in_byte >= dfx_pkg::CHAR_LOWER_A && in_byte <= dfx_pkg::CHAR_LOWER_F) begin
      hex_digit = 4'(in_byte - dfx_pkg::CHAR_LOWER_A + 8'd10);
    end else if (in_byte >= dfx_pkg::CHAR_UPPER_A && in_byte <= dfx_pkg::CHAR_UPPER_F) begin
      hex_digit = 4'(in_byte - dfx_pkg::CHAR_UPPER_A + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  // times ten as shift-add for the decimal fields; the checksum is times sixteen
  assign sensor_prod = ({4'b0, sensor_acc} << 3) + ({4'b0, sensor_acc} << 1)
                     + dfx_pkg::ID_CALC_BITS'(digit);
  assign value_prod  = ({4'b0, value_acc} << 3) + ({4'b0, value_acc} << 1)
                     + dfx_pkg::ID_CALC_BITS'(digit);
  assign mant_prod   = ({4'b0, mant_acc} << 3) + ({4'b0, mant_acc} << 1)
                     + dfx_pkg::MANT_CALC_BITS'(digit);
  assign checksum_prod = ({4'b0, checksum} << 4) + dfx_pkg::CHECKSUM_CALC_BITS'(hex_digit);

  always_comb begin
    sep_count_next   = sep_count;
    running_xor_next = running_xor;
    sensor_acc_next  = sensor_acc;
    value_acc_next   = value_acc;
    mant_acc_next    = mant_acc;
    negative_next    = negative;
    started_next     = started;
    has_digit_next   = has_digit;
    point_seen_next  = point_seen;
    fraction_next    = fraction;
    invalid_next     = invalid;
    checksum_next    = checksum;

    if (sep_count < dfx_pkg::FIELD_CHECKSUM) begin
      running_xor_next = running_xor ^ in_byte;
    end

    priority if (in_byte == dfx_pkg::CHAR_SEPARATOR) begin
      if (sep_count < dfx_pkg::SEPARATORS_NEEDED) begin
        sep_count_next = sep_count + 1'b1;
      end
    end else if (sep_count == dfx_pkg::FIELD_SENSOR) begin
      if (is_digit) begin
        sensor_acc_next = (sensor_prod > ID_LIMIT) ? ID_LIMIT[dfx_pkg::ID_ACC_BITS-1:0]
                                                   : sensor_prod[dfx_pkg::ID_ACC_BITS-1:0];
      end else begin
        invalid_next[0] = 1'b1;
      end
    end else if (sep_count == dfx_pkg::FIELD_VALUE) begin
      if (is_digit) begin
        value_acc_next = (value_prod > ID_LIMIT) ? ID_LIMIT[dfx_pkg::ID_ACC_BITS-1:0]
                                                 : value_prod[dfx_pkg::ID_ACC_BITS-1:0];
      end else begin
        invalid_next[1] = 1'b1;
      end
    end else if (sep_count == dfx_pkg::FIELD_NUMBER) begin
      if (!invalid[2]) begin
        priority if ((in_byte == dfx_pkg::CHAR_PLUS || in_byte == dfx_pkg::CHAR_MINUS)
                     && !started) begin
          negative_next = (in_byte == dfx_pkg::CHAR_MINUS);
          started_next  = 1'b1;
        end else if (is_digit) begin
          started_next   = 1'b1;
          has_digit_next = 1'b1;
          if (!point_seen || fraction < FRACTION_LIMIT) begin
            if (point_seen) begin
              fraction_next = fraction + 1'b1;
            end
            mant_acc_next = (mant_prod > MANT_CAP) ? MANT_CAP[dfx_pkg::MANTISSA_BITS-1:0]
                                                   : mant_prod[dfx_pkg::MANTISSA_BITS-1:0];
          end
        end else if (in_byte == dfx_pkg::CHAR_POINT && !point_seen) begin
          point_seen_next = 1'b1;
          started_next    = 1'b1;
        end else begin
          invalid_next[2] = 1'b1;
        end
      end
    end else if (sep_count == dfx_pkg::FIELD_CHECKSUM) begin
      if (is_hex) begin
        checksum_next = (checksum_prod > CHECKSUM_MAX)
                      ? CHECKSUM_MAX[dfx_pkg::CHECKSUM_BITS-1:0]
                      : checksum_prod[dfx_pkg::CHECKSUM_BITS-1:0];
      end else begin
        invalid_next[3] = 1'b1;
      end
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      summary_valid <= 1'b0;
      sep_count     <= '0;
      running_xor   <= '0;
      sensor_acc    <= '0;
      value_acc     <= '0;
      mant_acc      <= '0;
      negative      <= 1'b0;
      started       <= 1'b0;
      has_digit     <= 1'b0;
      point_seen    <= 1'b0;
      fraction      <= '0;
      invalid       <= '0;
      checksum      <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
        in_byte  <= s_tdata;
        in_last  <= s_tlast;
      end

      if (summary_valid && summary_ready) begin
        summary_valid <= 1'b0;
      end

      if (consume) begin
        if (in_last) begin
          summary_valid        <= 1'b1;
          summary.incomplete   <= (sep_count_next < dfx_pkg::SEPARATORS_NEEDED);
          summary.running_xor  <= running_xor_next;
          summary.checksum     <= invalid_next[3] ? '0 : checksum_next;
          summary.sensor_id    <= invalid_next[0] ? '0 : sensor_acc_next;
          summary.value_id     <= invalid_next[1] ? '0 : value_acc_next;
          summary.number_ok    <= !invalid_next[2] && has_digit_next;
          summary.negative     <= negative_next;
          summary.magnitude    <= mant_acc_next;
          summary.fraction     <= fraction_next;
          sep_count   <= '0;
          running_xor <= '0;
          sensor_acc  <= '0;
          value_acc   <= '0;
          mant_acc    <= '0;
          negative    <= 1'b0;
          started     <= 1'b0;
          has_digit   <= 1'b0;
          point_seen  <= 1'b0;
          fraction    <= '0;
          invalid     <= '0;
          checksum    <= '0;
        end else begin
          sep_count   <= sep_count_next;
          running_xor <= running_xor_next;
          sensor_acc  <= sensor_acc_next;
          value_acc   <= value_acc_next;
          mant_acc    <= mant_acc_next;
          negative    <= negative_next;
          started     <= started_next;
          has_digit   <= has_digit_next;
          point_seen  <= point_seen_next;
          fraction    <= fraction_next;
          invalid     <= invalid_next;
          checksum    <= checksum_next;
        end
      end
    end
  end

endmodule

[design/dfx_frame_check.sv]
`timescale 1ns / 1ps
module dfx_frame_check (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dfx_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [dfx_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                summary_valid,
  output logic                                summary_ready,
  input  dfx_pkg::frame_summary_t             summary,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [dfx_pkg::OUT_DATA_BITS-1:0]   m_tdata
);

  localparam logic [dfx_pkg::MANTISSA_BITS-1:0] MANT_POS_MAX =
    {1'b0, {(dfx_pkg::MANTISSA_BITS-1){1'b1}}};

  logic [dfx_pkg::ID_BITS-1:0] sensor_count;
  logic [dfx_pkg::ID_BITS-1:0] value_count;
  logic [dfx_pkg::ID_BITS-1:0] last_sensor_id;
  logic [dfx_pkg::ID_BITS-1:0] last_value_id;

  dfx_pkg::status_t                  status;
  logic [dfx_pkg::ID_BITS-1:0]       sensor_out, value_out;
  logic [dfx_pkg::MANTISSA_BITS-1:0] mantissa;
  logic [dfx_pkg::FRACTION_BITS-1:0] fraction;
  logic                              id_overflow;

  assign summary_ready = !m_tvalid || m_tready;
  assign id_overflow   = summary.sensor_id[dfx_pkg::ID_BITS]
                      || summary.value_id[dfx_pkg::ID_BITS];

  always_comb begin
    mantissa = '0;
    fraction = '0;
    if (summary.number_ok) begin
      fraction = summary.fraction;
      if (summary.negative) begin
        mantissa = ~summary.magnitude + 1'b1;
      end else begin
        mantissa = summary.magnitude[dfx_pkg::MANTISSA_BITS-1] ? MANT_POS_MAX
                                                                 : summary.magnitude;
      end
    end

    sensor_out = summary.sensor_id[dfx_pkg::ID_BITS] ? '1
                                                     : summary.sensor_id[dfx_pkg::ID_BITS-1:0];
    value_out  = summary.value_id[dfx_pkg::ID_BITS] ? '1
                                                    : summary.value_id[dfx_pkg::ID_BITS-1:0];

    priority if (summary.incomplete) begin
      status     = dfx_pkg::STATUS_INCOMPLETE;
      sensor_out = '0;
      value_out  = '0;
      mantissa   = '0;
      fraction   = '0;
    end else if (summary.checksum != {8'b0, summary.running_xor}) begin
      status = dfx_pkg::STATUS_CHECKSUM;
    end else if (summary.sensor_id == {1'b0, last_sensor_id}
                 && summary.value_id == {1'b0, last_value_id}) begin
      status = dfx_pkg::STATUS_DUPLICATE;
    end else if (id_overflow
                 || summary.sensor_id[dfx_pkg::ID_BITS-1:0] >= sensor_count
                 || summary.value_id[dfx_pkg::ID_BITS-1:0] >= value_count) begin
      status = dfx_pkg::STATUS_RANGE;
    end else begin
      status = dfx_pkg::STATUS_ACCEPTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_count   <= '0;
      value_count    <= '0;
      last_sensor_id <= '0;
      last_value_id  <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          dfx_pkg::REG_SENSOR_COUNT: sensor_count <= cfg_data;
          dfx_pkg::REG_VALUE_COUNT:  value_count  <= cfg_data;
          default: begin
          end
        endcase
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (summary_valid && summary_ready) begin
        m_tvalid <= 1'b1;
        m_tdata  <= dfx_pkg::OUT_DATA_BITS'({fraction, mantissa, value_out, sensor_out,
                                             status});
        if (status == dfx_pkg::STATUS_ACCEPTED) begin
          last_sensor_id <= sensor_out;
          last_value_id  <= value_out;
        end
      end
    end
  end

endmodule

[design/dollar_frame_xor_deframer.sv]
`timescale 1ns / 1ps
// Path: a frame's last byte passes the input register, the summary register and the output register to m_tvalid.
// Throughput: one byte per cycle unless a frame end is blocked; the per-byte field update is a single registered pass.
// Results wait in the output register; bytes keep flowing while no frame end is blocked.
// Reset (rst, synchronous): clears frame state, last accepted ids and both limits.
module dollar_frame_xor_deframer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dfx_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [dfx_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [dfx_pkg::IN_DATA_BITS-1:0]    s_tdata,  // [7:0] frame_byte
  input  logic                                s_tlast,  // frame_end
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [2:0] status, [10:3] sensor_id, [18:11] value_id, [50:19] value_mantissa,
  // [54:51] fraction_digits, [55] zero
  output logic [dfx_pkg::OUT_DATA_BITS-1:0]   m_tdata
);

  logic                    summary_valid;
  logic                    summary_ready;
  dfx_pkg::frame_summary_t summary;

  dfx_field_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .summary_valid (summary_valid),
    .summary_ready (summary_ready),
    .summary       (summary)
  );

  dfx_frame_check u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .summary_valid (summary_valid),
    .summary_ready (summary_ready),
    .summary       (summary),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata)
  );

endmodule

[tb/sv/dollar_frame_xor_deframer_tb.sv]
`timescale 1ns / 1ps
module dollar_frame_xor_deframer_tb;

  localparam int unsigned ID_LIMIT = 1 << dfx_pkg::ID_BITS;
  localparam int unsigned CHECKSUM_MAX = (1 << dfx_pkg::CHECKSUM_BITS) - 1;
  localparam longint unsigned MANT_CAP = 64'd1 << (dfx_pkg::MANTISSA_BITS - 1);

  typedef struct packed {
    logic                                     pad;
    logic [dfx_pkg::FRACTION_BITS-1:0]        fraction_digits;
    logic signed [dfx_pkg::MANTISSA_BITS-1:0] value_mantissa;
    logic [dfx_pkg::ID_BITS-1:0]              value_id;
    logic [dfx_pkg::ID_BITS-1:0]              sensor_id;
    dfx_pkg::status_t                         status;
  } frame_result_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_we = 1'b0;
  logic [dfx_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [dfx_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [dfx_pkg::IN_DATA_BITS-1:0]   s_tdata = '0;
  logic                               s_tlast = 1'b0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [dfx_pkg::OUT_DATA_BITS-1:0]  m_tdata;

  dollar_frame_xor_deframer uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Deframer prediction state
  logic [7:0]       lim_sensors;
  logic [7:0]       lim_values;
  logic [7:0]       xor_sum;
  logic [2:0]       sep_seen;
  int unsigned      sensor_acc;
  int unsigned      value_acc;
  longint unsigned  mag_acc;
  bit               mag_neg;
  bit               num_started;
  bit               num_digit;
  bit               point_seen;
  int unsigned      frac_count;
  logic [3:0]       bad_field;
  int unsigned      cs_acc;
  logic [7:0]       last_sid;
  logic [7:0]       last_vid;

  frame_result_t    frame_results[$];
  logic [7:0]       frame_bytes[$];
  int               mismatch_count = 0;
  int               bytes_sent = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               holdoff_left = 0;
  bit               byte_offered = 1'b0;

  logic [7:0] phase_sensor_limits [8] = '{8'd255, 8'd8, 8'd1, 8'd0, 8'd200, 8'd16, 8'd255, 8'd3};
  logic [7:0] phase_value_limits [8] = '{8'd255, 8'd4, 8'd1, 8'd255, 8'd3, 8'd16, 8'd0, 8'd255};
  int         mode_send_idle [4] = '{0, 78, 0, 15};
  int         mode_recv_stall [4] = '{0, 0, 78, 15};

  function automatic bit is_digit(logic [7:0] b);
    return b >= dfx_pkg::CHAR_ZERO && b <= dfx_pkg::CHAR_NINE;
  endfunction

  function automatic int hex_value(logic [7:0] b);
    if (is_digit(b)) return int'(b - dfx_pkg::CHAR_ZERO);
    if (b >= dfx_pkg::CHAR_LOWER_A && b <= dfx_pkg::CHAR_LOWER_F)
      return int'(b - dfx_pkg::CHAR_LOWER_A) + 10;
    if (b >= dfx_pkg::CHAR_UPPER_A && b <= dfx_pkg::CHAR_UPPER_F)
      return int'(b - dfx_pkg::CHAR_UPPER_A) + 10;
    return -1;
  endfunction

  function automatic int unsigned id_digit(int unsigned acc, int unsigned d);
    int unsigned v;
    v = acc * 10 + d;
    return (v > ID_LIMIT) ? ID_LIMIT : v;
  endfunction

  function void clear_frame_state();
    xor_sum = '0;
    sep_seen = '0;
    sensor_acc = 0;
    value_acc = 0;
    mag_acc = 0;
    mag_neg = 1'b0;
    num_started = 1'b0;
    num_digit = 1'b0;
    point_seen = 1'b0;
    frac_count = 0;
    bad_field = '0;
    cs_acc = 0;
  endfunction

  function void mantissa_digit(int unsigned d);
    if (mag_acc > (MANT_CAP - d) / 10) mag_acc = MANT_CAP;
    else mag_acc = mag_acc * 10 + d;
  endfunction

  function void number_byte(logic [7:0] b);
    if (bad_field[2]) return;
    if ((b == dfx_pkg::CHAR_PLUS || b == dfx_pkg::CHAR_MINUS) && !num_started) begin
      mag_neg = (b == dfx_pkg::CHAR_MINUS);
      num_started = 1'b1;
    end else if (is_digit(b)) begin
      num_started = 1'b1;
      num_digit = 1'b1;
      if (point_seen) begin
        if (frac_count < dfx_pkg::MAX_FRACTION_DIGITS) begin
          frac_count++;
          mantissa_digit(b - dfx_pkg::CHAR_ZERO);
        end
      end else begin
        mantissa_digit(b - dfx_pkg::CHAR_ZERO);
      end
    end else if (b == dfx_pkg::CHAR_POINT && !point_seen) begin
      point_seen = 1'b1;
      num_started = 1'b1;
    end else begin
      bad_field[2] = 1'b1;
    end
  endfunction

  function void deframe_byte(logic [7:0] b, bit last);
    frame_result_t                     r;
    int unsigned                       sid;
    int unsigned                       vid;
    int unsigned                       cs;
    int                                hv;
    logic [dfx_pkg::MANTISSA_BITS-1:0] mant;
    int unsigned                       frac;
    if (sep_seen < dfx_pkg::FIELD_CHECKSUM) xor_sum ^= b;
    if (b == dfx_pkg::CHAR_SEPARATOR) begin
      if (sep_seen < dfx_pkg::SEPARATORS_NEEDED) sep_seen++;
    end else begin
      case (sep_seen)
        dfx_pkg::FIELD_SENSOR: begin
          if (is_digit(b)) sensor_acc = id_digit(sensor_acc, b - dfx_pkg::CHAR_ZERO);
          else bad_field[0] = 1'b1;
        end
        dfx_pkg::FIELD_VALUE: begin
          if (is_digit(b)) value_acc = id_digit(value_acc, b - dfx_pkg::CHAR_ZERO);
          else bad_field[1] = 1'b1;
        end
        dfx_pkg::FIELD_NUMBER: number_byte(b);
        dfx_pkg::FIELD_CHECKSUM: begin
          hv = hex_value(b);
          if (hv < 0) begin
            bad_field[3] = 1'b1;
          end else begin
            cs = cs_acc * 16 + hv;
            cs_acc = (cs > CHECKSUM_MAX) ? CHECKSUM_MAX : cs;
          end
        end
        default: ;
      endcase
    end
    if (!last) return;

    sid = bad_field[0] ? 0 : sensor_acc;
    vid = bad_field[1] ? 0 : value_acc;
    cs = bad_field[3] ? 0 : cs_acc;
    mant = '0;
    frac = 0;
    if (!bad_field[2] && num_digit) begin
      frac = frac_count;
      if (mag_neg) mant = dfx_pkg::MANTISSA_BITS'(~mag_acc + 64'd1);
      else mant = (mag_acc >= MANT_CAP) ? dfx_pkg::MANTISSA_BITS'(MANT_CAP - 1)
                                        : dfx_pkg::MANTISSA_BITS'(mag_acc);
    end

    if (sep_seen < dfx_pkg::SEPARATORS_NEEDED) begin
      r.status = dfx_pkg::STATUS_INCOMPLETE;
      sid = 0;
      vid = 0;
      mant = '0;
      frac = 0;
    end else if (cs != xor_sum) begin
      r.status = dfx_pkg::STATUS_CHECKSUM;
    end else if (sid == last_sid && vid == last_vid) begin
      r.status = dfx_pkg::STATUS_DUPLICATE;
    end else if (sid > ID_LIMIT - 1 || vid > ID_LIMIT - 1 ||
                 sid >= lim_sensors || vid >= lim_values) begin
      r.status = dfx_pkg::STATUS_RANGE;
    end else begin
      r.status = dfx_pkg::STATUS_ACCEPTED;
      last_sid = dfx_pkg::ID_BITS'(sid);
      last_vid = dfx_pkg::ID_BITS'(vid);
    end

    r.pad = 1'b0;
    r.sensor_id = (sid > ID_LIMIT - 1) ? dfx_pkg::ID_BITS'(ID_LIMIT - 1)
                                       : dfx_pkg::ID_BITS'(sid);
    r.value_id = (vid > ID_LIMIT - 1) ? dfx_pkg::ID_BITS'(ID_LIMIT - 1)
                                      : dfx_pkg::ID_BITS'(vid);
    r.value_mantissa = mant;
    r.fraction_digits = dfx_pkg::FRACTION_BITS'(frac);
    frame_results.push_back(r);
    clear_frame_state();
  endfunction

  function void note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  function void check_frame_result(logic [dfx_pkg::OUT_DATA_BITS-1:0] data);
    frame_result_t got;
    frame_result_t want;
    got = frame_result_t'(data);
    if (frame_results.size() == 0) begin
      note_failure($sformatf("unexpected result: status=%0d sensor=%0d value=%0d",
                             got.status, got.sensor_id, got.value_id));
      return;
    end
    want = frame_results.pop_front();
    if (got.status !== want.status || got.sensor_id !== want.sensor_id ||
        got.value_id !== want.value_id || got.value_mantissa !== want.value_mantissa ||
        got.fraction_digits !== want.fraction_digits || got.pad !== 1'b0) begin
      note_failure($sformatf({"result mismatch: expected status=%0d sensor=%0d value=%0d ",
                              "mantissa=%0d fraction=%0d, got status=%0d sensor=%0d ",
                              "value=%0d mantissa=%0d fraction=%0d pad=%0b"},
                             want.status, want.sensor_id, want.value_id,
                             want.value_mantissa, want.fraction_digits,
                             got.status, got.sensor_id, got.value_id,
                             got.value_mantissa, got.fraction_digits, got.pad));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_frame_result(m_tdata);
  end

  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      m_tready <= 1'b0;
      holdoff_left = holdoff_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("dollar_frame_xor_deframer_tb NOT OK");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    byte_offered = 1'b1;
    do @(posedge clk); while (!s_tready);
    deframe_byte(b, last);
    bytes_sent++;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      byte_offered = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    if (byte_offered) begin
      s_tvalid <= 1'b0;
      byte_offered = 1'b0;
    end
    while (frame_results.size() != 0) @(posedge clk);
    // cover bytes still in flight that carry no result
    repeat (6) @(posedge clk);
  endtask

  task automatic set_limits(input logic [7:0] sensors, input logic [7:0] values);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= dfx_pkg::REG_SENSOR_COUNT;
    cfg_data <= sensors;
    @(posedge clk);
    lim_sensors = sensors;
    cfg_index <= dfx_pkg::REG_VALUE_COUNT;
    cfg_data <= values;
    @(posedge clk);
    lim_values = values;
    cfg_we <= 1'b0;
  endtask

  task automatic set_mode(input int idx);
    send_idle_pct = mode_send_idle[idx];
    recv_stall_pct = mode_recv_stall[idx];
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endfunction

  // checksum covers every byte queued so far
  function automatic void put_checksum(bit good, string prefix);
    logic [7:0] x;
    x = '0;
    foreach (frame_bytes[i]) x ^= frame_bytes[i];
    if (!good) x ^= 8'($urandom_range(1, 255));
    put_text(prefix);
    put_text($urandom_range(1) ? $sformatf("%02x", x) : $sformatf("%02X", x));
  endfunction

  task automatic send_frame();
    int n;
    n = frame_bytes.size();
    for (int i = 0; i < n; i++) send_byte(frame_bytes[i], i == n - 1);
    frame_bytes.delete();
  endtask

  task automatic checked_frame(input string fields, input bit good, input string tail);
    put_text(fields);
    put_checksum(good, "");
    put_text({"$", tail});
    send_frame();
  endtask

  function automatic string id_text(int unsigned v);
    int r;
    r = $urandom_range(19);
    if (r == 0) return "";
    if (r == 1) return {"0", $sformatf("%0d", v)};
    return $sformatf("%0d", v);
  endfunction

  function automatic int unsigned pick_id(logic [7:0] lim);
    if ($urandom_range(9) == 0) return $urandom_range(256, 99999);
    return $urandom_range(0, (lim > 250) ? 255 : lim + 2);
  endfunction

  function automatic string number_text();
    string s;
    int    n;
    s = "";
    case ($urandom_range(2))
      1: s = "+";
      2: s = "-";
      default: ;
    endcase
    n = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 3);
    repeat (n) s = {s, $sformatf("%0d", $urandom_range(9))};
    if ($urandom_range(1)) begin
      s = {s, "."};
      n = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
      repeat (n) s = {s, $sformatf("%0d", $urandom_range(9))};
    end
    return s;
  endfunction

  task automatic random_frame();
    int          kind;
    int unsigned sid;
    int unsigned vid;
    logic [7:0]  b;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      repeat ($urandom_range(1, 20))
        frame_bytes.push_back(($urandom_range(3) == 0) ? dfx_pkg::CHAR_SEPARATOR
                                                       : 8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(0, 3)) begin
        b = 8'($urandom_range(255));
        frame_bytes.push_back((b == dfx_pkg::CHAR_SEPARATOR) ? dfx_pkg::CHAR_UPPER_A : b);
      end
      if ($urandom_range(9) == 0) begin
        sid = last_sid;
        vid = last_vid;
      end else begin
        sid = pick_id(lim_sensors);
        vid = pick_id(lim_values);
      end
      put_text({"$", id_text(sid), "$", id_text(vid), "$", number_text(), "$"});
      put_checksum($urandom_range(99) < 85, ($urandom_range(9) == 0) ? "0" : "");
      frame_bytes.push_back(dfx_pkg::CHAR_SEPARATOR);
      if ($urandom_range(9) < 3)
        repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(255)));
      // corrupt one byte or cut the frame short
      if (kind >= 70) begin
        if ($urandom_range(1))
          frame_bytes[$urandom_range(frame_bytes.size() - 1)] = 8'($urandom_range(255));
        else
          repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());
      end
    end
    send_frame();
  endtask

  task automatic test_reset_limits();
    set_mode(0);
    checked_frame("$1$1$5$", 1'b1, "");
    checked_frame("$0$0$5$", 1'b1, "");
  endtask

  task automatic test_directed_frames();
    string odd_numbers [8] = '{"1e5", "1.2.3", " 1", "1-", "-.", "+.5", ".", "0.1234567890123"};
    set_limits(8'd255, 8'd255);
    checked_frame("$7$3$12.5$", 1'b1, "");
    checked_frame("$7$3$12.5$", 1'b1, "");
    checked_frame("$7$4$-0.001$", 1'b0, "");
    put_text("$7$4$1$");
    send_frame();
    frame_bytes.push_back(dfx_pkg::CHAR_SEPARATOR);
    send_frame();
    frame_bytes.push_back(8'hFF);
    send_frame();
    frame_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    checked_frame("$9$9$+3.14159265358979$", 1'b1, "");
    checked_frame("$300$1$5$", 1'b1, "");
    checked_frame("$12$99999$1$", 1'b1, "");
    checked_frame("$+5$1$1$", 1'b1, "");
    checked_frame("$$$$", 1'b1, "");
    checked_frame("$2$2$99999999999$", 1'b1, "");
    checked_frame("$2$3$-99999999999$", 1'b1, "");
    checked_frame("$2$4$-2147483648$", 1'b1, "");
    checked_frame("$2$5$2147483647$", 1'b1, "");
    foreach (odd_numbers[i])
      checked_frame({"$3$", $sformatf("%0d", i + 1), "$", odd_numbers[i], "$"}, 1'b1, "");
    put_text("$5$1$1$4G$");
    send_frame();
    put_text("$5$2$1$FFFFF$");
    send_frame();
    put_text("$5$3$1$");
    put_checksum(1'b1, "000");
    frame_bytes.push_back(dfx_pkg::CHAR_SEPARATOR);
    send_frame();
    checked_frame("$4$1$1$", 1'b1, "extra$$1");
    put_text("GP$5$");
    send_frame();
  endtask

  task automatic test_backpressure();
    set_limits(8'd20, 8'd20);
    set_mode(0);
    holdoff_left = 300;
    repeat (40) begin
      frame_bytes.push_back($urandom_range(1) ? dfx_pkg::CHAR_SEPARATOR : dfx_pkg::CHAR_UPPER_A);
      send_frame();
    end
    repeat (5) random_frame();
    drain_results();
  endtask

  task automatic test_drain_pause();
    set_mode(3);
    repeat (4) begin
      random_frame();
      random_frame();
      drain_results();
    end
  endtask

  task automatic test_random_phases();
    int phase_start;
    for (int p = 0; p < 8; p++) begin
      set_limits(phase_sensor_limits[p], phase_value_limits[p]);
      set_mode(p % 4);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 140) random_frame();
    end
  endtask

  initial begin
    lim_sensors = '0;
    lim_values = '0;
    last_sid = '0;
    last_vid = '0;
    clear_frame_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_limits();
    test_directed_frames();
    test_backpressure();
    test_drain_pause();
    test_random_phases();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && frame_results.size() == 0) begin
      $display("dollar_frame_xor_deframer_tb OK");
    end else begin
      $display("dollar_frame_xor_deframer_tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
design/dfx_pkg.sv
design/dfx_field_parser.sv
design/dfx_frame_check.sv
design/dollar_frame_xor_deframer.sv
tb/sv/dollar_frame_xor_deframer_tb.sv
